>>> src/sem_pkg.sv
package sem_pkg;

   localparam int WORD_COUNT = 256;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int WORD_W     = 16;

   localparam logic [1:0] KIND_CTRL_WR = 2'd0;
   localparam logic [1:0] KIND_RAM_WR  = 2'd1;
   localparam logic [1:0] KIND_RAM_RD  = 2'd2;

   localparam logic [15:0] EEP_PORT_ADDR  = 16'ha080;
   localparam logic [15:0] BANK_SEL_MASK  = 16'h6000;
   localparam logic [15:0] BANK_SEL_MATCH = 16'h2000;
   localparam logic [15:0] RD_GROUP_MASK  = 16'ha0f0;
   localparam logic [15:0] RD_GROUP_A000  = 16'ha000;
   localparam logic [15:0] RD_GROUP_A010  = 16'ha010;
   localparam logic [15:0] RD_GROUP_A060  = 16'ha060;
   localparam logic [15:0] RD_GROUP_A070  = 16'ha070;
   localparam logic [15:0] RD_GROUP_EEP   = 16'ha080;
   localparam logic [7:0]  RD_OPEN_BUS    = 8'hff;

   typedef struct packed {
      logic       go;
      logic [7:0] data;
   } eep_cmd_type;

   typedef struct packed {
      logic busy;
      logic dout;
   } eep_stat_type;

endpackage

>>> src/serial_eeprom_cartridge_mapper.sv
// channel  direction  fields
// req      in         tuser: kind; tdata: bus_address, bus_data
// rsp      out        tdata: read_data, rom_bank
// csr      in         wdata: rom_bank_mask
//
// an item is captured in ST_IDLE, then executed in ST_EXEC, which loads the result register
// a serial read command holds off new items (busy) while the word store's registered read port returns
// while a result waits untaken, execution holds; the next item is still captured
// reset is synchronous; the erased store is modelled by valid bits, so no clearing pass
module serial_eeprom_cartridge_mapper
   import sem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic [23:0] req_tdata,   // [15:0] bus_address, [23:16] bus_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [14:8] rom_bank, [15] zero
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type    state_ff;
   logic [1:0]   kind_ff;
   logic [15:0]  addr_ff;
   logic [7:0]   data_ff;
   logic [6:0]   bank_ff, bank_in;
   logic [6:0]   mask_ff;
   logic         rsp_valid_ff;
   logic [7:0]   rd_ff, rd_in;
   logic [6:0]   rsp_bank_ff;
   logic         slot_free;
   logic         exec_go;
   logic [15:0]  grp;
   eep_cmd_type  eep_cmd;
   eep_stat_type eep_stat;

   assign req_tready = (state_ff == ST_IDLE) && !eep_stat.busy;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign exec_go    = (state_ff == ST_EXEC) && slot_free;
   assign grp        = addr_ff & RD_GROUP_MASK;

   assign eep_cmd.go   = exec_go && (kind_ff == KIND_RAM_WR) && (addr_ff == EEP_PORT_ADDR);
   assign eep_cmd.data = data_ff;

   always_comb begin
      bank_in = bank_ff;
      rd_in   = 8'd0;
      unique case (kind_ff)
         KIND_CTRL_WR: begin
            if ((addr_ff & BANK_SEL_MASK) == BANK_SEL_MATCH) begin
               bank_in = (data_ff[6:0] == 7'd0) ? 7'd1 : data_ff[6:0];
            end
         end
         KIND_RAM_RD: begin
            if (grp == RD_GROUP_A000 || grp == RD_GROUP_A010 ||
                grp == RD_GROUP_A060 || grp == RD_GROUP_A070) begin
               rd_in = 8'd0;
            end else if (grp == RD_GROUP_EEP) begin
               rd_in = {7'd0, eep_stat.dout};
            end else begin
               rd_in = RD_OPEN_BUS;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 7'd1;
         mask_ff      <= 7'h7f;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  kind_ff  <= req_tuser;
                  addr_ff  <= req_tdata[15:0];
                  data_ff  <= req_tdata[23:16];
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (slot_free) begin
                  bank_ff     <= bank_in;
                  rd_ff       <= rd_in;
                  rsp_bank_ff <= bank_in & mask_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   sem_eeprom u_eeprom (
      .clock(clock),
      .reset(reset),
      .cmd  (eep_cmd),
      .stat (eep_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_bank_ff, rd_ff};

endmodule

>>> src/sem_ram.sv
module sem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sem_eeprom.sv
module sem_eeprom
   import sem_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  eep_cmd_type  cmd,
   output eep_stat_type stat
);

   typedef enum logic [2:0] {
      PH_OFF    = 3'd0,
      PH_CMD    = 3'd1,
      PH_ADDR   = 3'd2,
      PH_DATA   = 3'd3,
      PH_READ   = 3'd4,
      PH_COMMIT = 3'd5
   } phase_type;

   localparam logic [1:0] OP_EXT   = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_ERASE = 2'd3;

   localparam logic [1:0] EXT_WDS  = 2'd0;
   localparam logic [1:0] EXT_WRAL = 2'd1;
   localparam logic [1:0] EXT_ERAL = 2'd2;
   localparam logic [1:0] EXT_WEN  = 2'd3;

   phase_type         phase_ff, phase_in;
   logic              cs_ff, cs_in;
   logic              sk_ff, sk_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [1:0]        op_ff, op_in;
   logic [7:0]        addr_ff, addr_in;
   logic              idle_ff, idle_in;
   logic              wen_ff, wen_in;
   logic              dout_ff, dout_in;
   logic [WORD_W-1:0] fill_ff, fill_in;
   logic              load_ff, load_in;
   logic [WORD_COUNT-1:0] valid_ff;

   logic              mem_we;
   logic              fill_do;
   logic [WORD_W-1:0] mem_rdata;
   logic [WORD_AW-1:0] word_idx;
   logic              di;

   assign word_idx = addr_ff[WORD_AW-1:0];
   assign di       = cmd.data[1];

   always_comb begin
      phase_in = phase_ff;
      cs_in    = cs_ff;
      sk_in    = sk_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      idle_in  = idle_ff;
      wen_in   = wen_ff;
      dout_in  = dout_ff;
      fill_in  = fill_ff;
      load_in  = 1'b0;
      mem_we   = 1'b0;
      fill_do  = 1'b0;

      // word fetched last cycle lands in the shift register; unwritten words read as fill
      if (load_ff) begin
         shift_in = valid_ff[word_idx] ? mem_rdata : fill_ff;
      end

      if (cmd.go) begin
         cs_in = cmd.data[7];
         sk_in = cmd.data[6];

         // chip select edge is handled before the clock edge
         if (!cs_ff && cmd.data[7]) begin
            if (phase_ff == PH_COMMIT) begin
               mem_we   = wen_ff;
               phase_in = PH_OFF;
               dout_in  = 1'b1;
            end else begin
               idle_in  = 1'b1;
               phase_in = PH_OFF;
            end
         end

         if (!sk_ff && cmd.data[6]) begin
            if (idle_in) begin
               if (di) begin
                  idle_in  = 1'b0;
                  cnt_in   = 5'd0;
                  phase_in = PH_CMD;
               end
            end else begin
               unique case (phase_in)
                  PH_CMD: begin
                     shift_in = {shift_in[WORD_W-2:0], di};
                     cnt_in   = cnt_in + 5'd1;
                     if (cnt_in == 5'd2) begin
                        phase_in = PH_ADDR;
                        cnt_in   = 5'd0;
                        op_in    = shift_in[1:0];
                     end
                  end
                  PH_ADDR: begin
                     shift_in = {shift_in[WORD_W-2:0], di};
                     cnt_in   = cnt_in + 5'd1;
                     if (cnt_in == 5'd8) begin
                        phase_in = PH_DATA;
                        cnt_in   = 5'd0;
                        addr_in  = shift_in[7:0];
                        if (op_in == OP_EXT) begin
                           if (addr_in[7:6] == EXT_WDS) begin
                              wen_in   = 1'b0;
                              phase_in = PH_OFF;
                           end else if (addr_in[7:6] == EXT_WEN) begin
                              wen_in   = 1'b1;
                              phase_in = PH_OFF;
                           end
                        end
                     end
                  end
                  PH_DATA: begin
                     shift_in = {shift_in[WORD_W-2:0], di};
                     cnt_in   = cnt_in + 5'd1;
                     unique case (op_in)
                        OP_EXT: begin
                           if (cnt_in == 5'd16) begin
                              unique case (addr_in[7:6])
                                 EXT_WDS: begin
                                    wen_in   = 1'b0;
                                    phase_in = PH_OFF;
                                 end
                                 EXT_WRAL: begin
                                    fill_do  = wen_in;
                                    fill_in  = wen_in ? shift_in : fill_ff;
                                    phase_in = PH_COMMIT;
                                 end
                                 EXT_ERAL: begin
                                    fill_do  = wen_in;
                                    fill_in  = wen_in ? {WORD_W{1'b1}} : fill_ff;
                                    phase_in = PH_COMMIT;
                                 end
                                 default: begin
                                    wen_in   = 1'b1;
                                    phase_in = PH_OFF;
                                 end
                              endcase
                              cnt_in = 5'd0;
                           end
                        end
                        OP_WRITE: begin
                           if (cnt_in == 5'd16) begin
                              cnt_in   = 5'd0;
                              phase_in = PH_COMMIT;
                              dout_in  = 1'b0;
                           end
                        end
                        OP_READ: begin
                           if (cnt_in == 5'd1) begin
                              phase_in = PH_READ;
                              cnt_in   = 5'd0;
                              load_in  = 1'b1;
                           end
                        end
                        default: begin
                           if (cnt_in == 5'd16) begin
                              cnt_in   = 5'd0;
                              phase_in = PH_COMMIT;
                              dout_in  = 1'b0;
                              shift_in = {WORD_W{1'b1}};
                           end
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end

         if (sk_ff && !cmd.data[6] && phase_in == PH_READ) begin
            dout_in  = shift_in[WORD_W-1];
            shift_in = {shift_in[WORD_W-2:0], 1'b0};
            cnt_in   = cnt_in + 5'd1;
            if (cnt_in == 5'd16) begin
               cnt_in   = 5'd0;
               phase_in = PH_OFF;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OFF;
         cs_ff    <= 1'b0;
         sk_ff    <= 1'b0;
         shift_ff <= '0;
         cnt_ff   <= '0;
         op_ff    <= OP_EXT;
         addr_ff  <= '0;
         idle_ff  <= 1'b0;
         wen_ff   <= 1'b0;
         dout_ff  <= 1'b0;
         fill_ff  <= {WORD_W{1'b1}};
         load_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         cs_ff    <= cs_in;
         sk_ff    <= sk_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         idle_ff  <= idle_in;
         wen_ff   <= wen_in;
         dout_ff  <= dout_in;
         fill_ff  <= fill_in;
         load_ff  <= load_in;
         // a whole-store fill just drops every valid bit
         if (fill_do) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[word_idx] <= 1'b1;
         end
      end
   end

   sem_ram #(
      .WIDTH(WORD_W),
      .DEPTH(WORD_COUNT)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(word_idx),
      .wr_data(shift_ff),
      .rd_en  (load_in),
      .rd_addr(word_idx),
      .rd_data(mem_rdata)
   );

   assign stat.busy = load_ff;
   assign stat.dout = dout_ff;

endmodule

>>> src/sem_checker.sv
module sem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_we,
   input logic [6:0]  csr_wdata
);

   // a held result must not change under back-pressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item in flight: the cycle after an accept takes nothing new
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another executes");

   // read bytes are only zero, the data-out bit, or open bus
   a_rd_values: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'h00 || rsp_tdata[7:0] == 8'h01 ||
                      rsp_tdata[7:0] == 8'hff))
      else $error("unexpected read byte");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15])
      else $error("padding bit set");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result left after reset");

endmodule

bind serial_eeprom_cartridge_mapper sem_checker u_sem_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);
